// ===== rtl/jsld_pkg.sv =====
package jsld_pkg;

    // Fixed field widths
    localparam int JOINT_IDX_W = 5;
    localparam int VALUE_W     = 16;
    localparam int LIMIT_W     = 8;
    localparam int MASK_W      = 26;
    localparam int MASK_EXT_W  = 1 << JOINT_IDX_W;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 26;

    // Register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DISABLED_MASK     = 3'd0,
        CFG_ANGLE_THRESHOLD   = 3'd1,
        CFG_CURRENT_THRESHOLD = 3'd2,
        CFG_MISS_LIMIT        = 3'd3,
        CFG_HIT_LIMIT         = 3'd4
    } cfg_reg_t;

    // Reset values of the registers
    localparam logic [MASK_W-1:0]  DISABLED_MASK_RST     = '0;
    localparam logic [VALUE_W-1:0] ANGLE_THRESHOLD_RST   = 16'd715;
    localparam logic [VALUE_W-1:0] CURRENT_THRESHOLD_RST = 16'd410;
    localparam logic [LIMIT_W-1:0] MISS_LIMIT_RST        = 8'd5;
    localparam logic [LIMIT_W-1:0] HIT_LIMIT_RST         = 8'd10;

    typedef struct packed {
        logic [MASK_W-1:0]  disabled_mask;
        logic [VALUE_W-1:0] angle_threshold;
        logic [VALUE_W-1:0] current_threshold;
        logic [LIMIT_W-1:0] miss_limit;
        logic [LIMIT_W-1:0] hit_limit;
    } cfg_t;

    // One joint sample held in the input stage
    typedef struct packed {
        logic [JOINT_IDX_W-1:0] joint_index;
        logic [VALUE_W-1:0]     angle_error;
        logic [VALUE_W-1:0]     motor_current;
        logic                   body_dead;
        logic                   frame_last;
    } sample_t;

    // Status from the counter update back to the top level
    typedef struct packed {
        logic wr_en;
        logic lost;
    } upd_status_t;

endpackage

// ===== rtl/jsld_update.sv =====
module jsld_update #(
    parameter int NUM_JOINTS  = 26,
    parameter int COUNT_WIDTH = 8
) (
    input  jsld_pkg::cfg_t            cfg,
    input  jsld_pkg::sample_t         sample,
    input  logic [COUNT_WIDTH-1:0]    hit_cur,
    input  logic [COUNT_WIDTH-1:0]    miss_cur,
    output logic [COUNT_WIDTH-1:0]    hit_new,
    output logic [COUNT_WIDTH-1:0]    miss_new,
    output jsld_pkg::upd_status_t     status
);
    import jsld_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

    logic [MASK_EXT_W-1:0]  mask_ext;
    logic                   in_range;
    logic                   skip;
    logic                   ang_above;
    logic                   cur_below;
    logic [COUNT_WIDTH-1:0] hit_inc;
    logic [COUNT_WIDTH-1:0] miss_inc;
    logic [COUNT_WIDTH-1:0] hit_step;

    // Decide whether this sample touches the counters
    assign mask_ext = MASK_EXT_W'(cfg.disabled_mask);
    assign in_range = int'(sample.joint_index) < NUM_JOINTS;
    assign skip     = sample.body_dead || !in_range || mask_ext[sample.joint_index];

    // Threshold compares
    assign ang_above = sample.angle_error > cfg.angle_threshold;
    assign cur_below = sample.motor_current < cfg.current_threshold;

    // Saturating increments
    assign hit_inc  = (hit_cur == '1) ? hit_cur : hit_cur + 1'b1;
    assign miss_inc = (miss_cur == '1) ? miss_cur : miss_cur + 1'b1;

    // Hit: hits rise, misses clear; not above threshold: misses rise
    always_comb begin
        hit_step = hit_cur;
        miss_new = miss_cur;
        if (ang_above) begin
            if (cur_below) begin
                hit_step = hit_inc;
                miss_new = '0;
            end
        end else begin
            miss_new = miss_inc;
        end
    end

    // Too many misses drop the hit count
    assign hit_new = (CMP_W'(miss_new) > CMP_W'(cfg.miss_limit)) ? '0 : hit_step;

    assign status.wr_en = !skip;
    assign status.lost  = !skip && (CMP_W'(hit_new) > CMP_W'(cfg.hit_limit));

endmodule

// ===== rtl/joint_stiffness_loss_detector.sv =====
// Channel  | Direction | Handshake           | Payload
// s_       | in        | s_valid / s_ready   | joint sample (index, angle, current, flags)
// m_       | out       | m_valid / m_ready   | joint_id, joint_lost, frame_loss, frame_end
// cfg_     | in        | cfg_wr_en           | cfg_index, cfg_wdata
//
// A transaction enters an input register, the counter update runs between that
// register and the result register, so a result passes both registers in turn;
// one transaction is taken every cycle unless a stall on m_ holds the result register.
// Samples marked invalid are taken and dropped without a result.
// A stall on m_ holds the result register; the input register still fills once.
// Synchronous active-low reset clears all counters, the frame flag, the configuration registers and the valid flags.
module joint_stiffness_loss_detector #(
    parameter int NUM_JOINTS  = 26,
    parameter int COUNT_WIDTH = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration
    input  logic                                cfg_wr_en,
    input  logic [jsld_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [jsld_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Sample input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [jsld_pkg::JOINT_IDX_W-1:0]    s_joint_index,
    input  logic [jsld_pkg::VALUE_W-1:0]        s_angle_error,
    input  logic [jsld_pkg::VALUE_W-1:0]        s_motor_current,
    input  logic                                s_body_dead,
    input  logic                                s_sample_valid,
    input  logic                                s_frame_last,
    // Result output
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [jsld_pkg::JOINT_IDX_W-1:0]    m_joint_id,
    output logic                                m_joint_lost,
    output logic                                m_frame_loss,
    output logic                                m_frame_end
);
    import jsld_pkg::*;

    localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int IW = (JW > JOINT_IDX_W) ? JW : JOINT_IDX_W;

    cfg_t                   cfg_reg;
    logic                   s1_vld_reg;
    sample_t                s1_reg;
    logic                   m_valid_reg;
    logic [JOINT_IDX_W-1:0] m_joint_id_reg;
    logic                   m_joint_lost_reg;
    logic                   m_frame_loss_reg;
    logic                   m_frame_end_reg;
    logic                   frame_flag_reg;
    logic [COUNT_WIDTH-1:0] hit_cnt_reg  [NUM_JOINTS];
    logic [COUNT_WIDTH-1:0] miss_cnt_reg [NUM_JOINTS];

    logic                   advance;
    logic                   commit;
    logic [IW-1:0]          idx_ext;
    logic [JW-1:0]          sel;
    logic [COUNT_WIDTH-1:0] hit_new;
    logic [COUNT_WIDTH-1:0] miss_new;
    upd_status_t            status;
    logic                   frame_loss_next;

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.disabled_mask     <= DISABLED_MASK_RST;
            cfg_reg.angle_threshold   <= ANGLE_THRESHOLD_RST;
            cfg_reg.current_threshold <= CURRENT_THRESHOLD_RST;
            cfg_reg.miss_limit        <= MISS_LIMIT_RST;
            cfg_reg.hit_limit         <= HIT_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DISABLED_MASK:     cfg_reg.disabled_mask     <= cfg_wdata[MASK_W-1:0];
                CFG_ANGLE_THRESHOLD:   cfg_reg.angle_threshold   <= cfg_wdata[VALUE_W-1:0];
                CFG_CURRENT_THRESHOLD: cfg_reg.current_threshold <= cfg_wdata[VALUE_W-1:0];
                CFG_MISS_LIMIT:        cfg_reg.miss_limit        <= cfg_wdata[LIMIT_W-1:0];
                CFG_HIT_LIMIT:         cfg_reg.hit_limit         <= cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the result register frees the input register
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !s1_vld_reg || advance;
    assign commit  = s1_vld_reg && advance;

    // Input register; drop invalid samples here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (s_ready) begin
            s1_vld_reg <= s_valid && s_sample_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            s1_reg.joint_index   <= s_joint_index;
            s1_reg.angle_error   <= s_angle_error;
            s1_reg.motor_current <= s_motor_current;
            s1_reg.body_dead     <= s_body_dead;
            s1_reg.frame_last    <= s_frame_last;
        end
    end

    // Select the joint's counters
    assign idx_ext = IW'(s1_reg.joint_index);
    assign sel     = idx_ext[JW-1:0];

    jsld_update #(
        .NUM_JOINTS  (NUM_JOINTS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_update (
        .cfg      (cfg_reg),
        .sample   (s1_reg),
        .hit_cur  (hit_cnt_reg[sel]),
        .miss_cur (miss_cnt_reg[sel]),
        .hit_new  (hit_new),
        .miss_new (miss_new),
        .status   (status)
    );

    // Write back the counters of the committed sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_JOINTS; i++) begin
                hit_cnt_reg[i]  <= '0;
                miss_cnt_reg[i] <= '0;
            end
        end else if (commit && status.wr_en) begin
            hit_cnt_reg[sel]  <= hit_new;
            miss_cnt_reg[sel] <= miss_new;
        end
    end

    // Frame flag: set by a lost joint, clear after the last result of a frame
    assign frame_loss_next = frame_flag_reg || status.lost;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_flag_reg <= 1'b0;
        end else if (commit) begin
            frame_flag_reg <= frame_loss_next && !s1_reg.frame_last;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_joint_id_reg   <= s1_reg.joint_index;
            m_joint_lost_reg <= status.lost;
            m_frame_loss_reg <= frame_loss_next;
            m_frame_end_reg  <= s1_reg.frame_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_joint_id   = m_joint_id_reg;
    assign m_joint_lost = m_joint_lost_reg;
    assign m_frame_loss = m_frame_loss_reg;
    assign m_frame_end  = m_frame_end_reg;

endmodule

// ===== rtl/jsld_checker.sv =====
module jsld_checker #(
    parameter int NUM_JOINTS = 26
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             s_sample_valid,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [jsld_pkg::JOINT_IDX_W-1:0] m_joint_id,
    input logic                             m_joint_lost,
    input logic                             m_frame_loss,
    input logic                             m_frame_end
);

    // Hold a stalled result
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_joint_id) && $stable(m_joint_lost)
            && $stable(m_frame_loss) && $stable(m_frame_end))
        else $error("stalled result changed");

    // No result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        aresetn && !$past(aresetn) |-> !m_valid)
        else $error("result shown right after reset");

    // A lost joint always marks the frame
    a_lost_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_joint_lost |-> m_frame_loss)
        else $error("joint lost without frame loss");

    // An out-of-range joint is never flagged
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (int'(m_joint_id) >= NUM_JOINTS) |-> !m_joint_lost)
        else $error("out-of-range joint flagged");

    // A fresh result follows a valid transaction through the input and result registers
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_sample_valid, 2))
        else $error("result without a matching transaction");

endmodule

bind joint_stiffness_loss_detector jsld_checker #(
    .NUM_JOINTS (NUM_JOINTS)
) u_jsld_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_sample_valid (s_sample_valid),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_joint_id     (m_joint_id),
    .m_joint_lost   (m_joint_lost),
    .m_frame_loss   (m_frame_loss),
    .m_frame_end    (m_frame_end)
);

// ===== tb/sv/joint_loss_checker.sv =====
`timescale 1ns / 1ps

module joint_loss_checker #(
    parameter int NUM_JOINTS  = 26,
    parameter int COUNT_WIDTH = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [jsld_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [jsld_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [jsld_pkg::JOINT_IDX_W-1:0] s_joint_index,
    input  logic [jsld_pkg::VALUE_W-1:0]     s_angle_error,
    input  logic [jsld_pkg::VALUE_W-1:0]     s_motor_current,
    input  logic                             s_body_dead,
    input  logic                             s_sample_valid,
    input  logic                             s_frame_last,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [jsld_pkg::JOINT_IDX_W-1:0] m_joint_id,
    input  logic                             m_joint_lost,
    input  logic                             m_frame_loss,
    input  logic                             m_frame_end,
    output int                               mismatches,
    output int                               outstanding
);
    import jsld_pkg::*;

    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [JOINT_IDX_W-1:0] joint_id;
        logic                   joint_lost;
        logic                   frame_loss;
        logic                   frame_end;
    } joint_verdict_t;

    // Shadow of the detector: registers, per-joint counters and frame flag
    cfg_t                   regs;
    logic [COUNT_WIDTH-1:0] hit_cnt  [NUM_JOINTS];
    logic [COUNT_WIDTH-1:0] miss_cnt [NUM_JOINTS];
    logic                   frame_flagged;
    joint_verdict_t         verdict_q [$];
    int                     error_total = 0;

    function automatic logic [COUNT_WIDTH-1:0] bump_count(input logic [COUNT_WIDTH-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    task automatic flag_mismatch(input string what);
        if (error_total < MAX_REPORTS)
            $display("%0t checker: %s", $time, what);
        error_total++;
    endtask

    always @(posedge aclk) begin
        joint_verdict_t         got;
        joint_verdict_t         want;
        logic [JOINT_IDX_W-1:0] j;
        logic                   skip;
        logic                   lost;

        if (!aresetn) begin
            // Return to the reset state
            regs.disabled_mask     = DISABLED_MASK_RST;
            regs.angle_threshold   = ANGLE_THRESHOLD_RST;
            regs.current_threshold = CURRENT_THRESHOLD_RST;
            regs.miss_limit        = MISS_LIMIT_RST;
            regs.hit_limit         = HIT_LIMIT_RST;
            for (int i = 0; i < NUM_JOINTS; i++) begin
                hit_cnt[i]  = '0;
                miss_cnt[i] = '0;
            end
            frame_flagged = 1'b0;
            verdict_q.delete();
        end else begin
            // Compare an accepted result with the oldest prediction
            if (m_valid && m_ready) begin
                got = '{m_joint_id, m_joint_lost, m_frame_loss, m_frame_end};
                if (verdict_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result joint_id %0d", got.joint_id));
                end else begin
                    want = verdict_q.pop_front();
                    if (got.joint_id !== want.joint_id)
                        flag_mismatch($sformatf("joint_id got %0d want %0d",
                                                got.joint_id, want.joint_id));
                    if (got.joint_lost !== want.joint_lost)
                        flag_mismatch($sformatf("joint_lost got %0b want %0b (joint %0d)",
                                                got.joint_lost, want.joint_lost,
                                                want.joint_id));
                    if (got.frame_loss !== want.frame_loss)
                        flag_mismatch($sformatf("frame_loss got %0b want %0b (joint %0d)",
                                                got.frame_loss, want.frame_loss,
                                                want.joint_id));
                    if (got.frame_end !== want.frame_end)
                        flag_mismatch($sformatf("frame_end got %0b want %0b (joint %0d)",
                                                got.frame_end, want.frame_end,
                                                want.joint_id));
                end
            end

            // Predict the result of an accepted sample; drop invalid ones
            if (s_valid && s_ready && s_sample_valid) begin
                j    = s_joint_index;
                lost = 1'b0;
                skip = s_body_dead || (int'(j) >= NUM_JOINTS);
                if (!skip)
                    skip = regs.disabled_mask[j];
                if (!skip) begin
                    if (s_angle_error > regs.angle_threshold) begin
                        if (s_motor_current < regs.current_threshold) begin
                            hit_cnt[j]  = bump_count(hit_cnt[j]);
                            miss_cnt[j] = '0;
                        end
                    end else begin
                        miss_cnt[j] = bump_count(miss_cnt[j]);
                    end
                    if (miss_cnt[j] > regs.miss_limit)
                        hit_cnt[j] = '0;
                    if (hit_cnt[j] > regs.hit_limit) begin
                        lost          = 1'b1;
                        frame_flagged = 1'b1;
                    end
                end
                verdict_q.push_back('{j, lost, frame_flagged, s_frame_last});
                // A frame end starts a fresh frame
                if (s_frame_last)
                    frame_flagged = 1'b0;
            end

            // Track register writes; unknown indexes change nothing
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_DISABLED_MASK:     regs.disabled_mask     = cfg_wdata[MASK_W-1:0];
                    CFG_ANGLE_THRESHOLD:   regs.angle_threshold   = cfg_wdata[VALUE_W-1:0];
                    CFG_CURRENT_THRESHOLD: regs.current_threshold = cfg_wdata[VALUE_W-1:0];
                    CFG_MISS_LIMIT:        regs.miss_limit        = cfg_wdata[LIMIT_W-1:0];
                    CFG_HIT_LIMIT:         regs.hit_limit         = cfg_wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
        end

        outstanding <= verdict_q.size();
        mismatches  <= error_total;
    end

endmodule

// ===== tb/sv/joint_stiffness_loss_detector_tb.sv =====
`timescale 1ns / 1ps

module joint_stiffness_loss_detector_tb;
    import jsld_pkg::*;

    localparam int NUM_JOINTS    = 26;
    localparam int COUNT_WIDTH   = 8;
    localparam int IDLE_PCT      = 16;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 2000;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic [JOINT_IDX_W-1:0] s_joint_index;
    logic [VALUE_W-1:0]     s_angle_error;
    logic [VALUE_W-1:0]     s_motor_current;
    logic                   s_body_dead;
    logic                   s_sample_valid;
    logic                   s_frame_last;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [JOINT_IDX_W-1:0] m_joint_id;
    logic                   m_joint_lost;
    logic                   m_frame_loss;
    logic                   m_frame_end;

    int   mismatches;
    int   outstanding;
    int   quiet_cycles = 0;
    bit   steady = 1'b0;
    cfg_t active;

    always #5 aclk = ~aclk;

    joint_stiffness_loss_detector #(
        .NUM_JOINTS (NUM_JOINTS),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_joint_index  (s_joint_index),
        .s_angle_error  (s_angle_error),
        .s_motor_current(s_motor_current),
        .s_body_dead    (s_body_dead),
        .s_sample_valid (s_sample_valid),
        .s_frame_last   (s_frame_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_joint_id     (m_joint_id),
        .m_joint_lost   (m_joint_lost),
        .m_frame_loss   (m_frame_loss),
        .m_frame_end    (m_frame_end)
    );

    joint_loss_checker #(
        .NUM_JOINTS (NUM_JOINTS),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_joint_index  (s_joint_index),
        .s_angle_error  (s_angle_error),
        .s_motor_current(s_motor_current),
        .s_body_dead    (s_body_dead),
        .s_sample_valid (s_sample_valid),
        .s_frame_last   (s_frame_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_joint_id     (m_joint_id),
        .m_joint_lost   (m_joint_lost),
        .m_frame_loss   (m_frame_loss),
        .m_frame_end    (m_frame_end),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    // Stall the result channel at random, except during the steady stretch
    always @(negedge aclk) begin
        m_ready <= aresetn && (steady || $urandom_range(99) >= IDLE_PCT);
    end

    // End the run when no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Offer one sample, optionally after a one-cycle gap, and hold until taken
    task automatic send_sample(input logic [JOINT_IDX_W-1:0] joint,
                               input logic [VALUE_W-1:0] angle,
                               input logic [VALUE_W-1:0] current,
                               input logic dead, input logic sample_ok, input logic last);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid         <= 1'b1;
        s_joint_index   <= joint;
        s_angle_error   <= angle;
        s_motor_current <= current;
        s_body_dead     <= dead;
        s_sample_valid  <= sample_ok;
        s_frame_last    <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering, wait for every predicted result, then let the pipe empty
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
    endtask

    // Write every register (junk above each field but the full-width mask) plus one unused index
    task automatic load_settings(input cfg_t c);
        logic [31:0]            junk;
        logic [CFG_INDEX_W-1:0] spare_idx;
        junk      = $urandom;
        spare_idx = CFG_INDEX_W'($urandom_range((1 << CFG_INDEX_W) - 1,
                                                int'(CFG_HIT_LIMIT) + 1));
        write_reg(CFG_DISABLED_MASK, c.disabled_mask);
        write_reg(CFG_ANGLE_THRESHOLD, {junk[25:16], c.angle_threshold});
        write_reg(CFG_CURRENT_THRESHOLD, {junk[9:0], c.current_threshold});
        write_reg(CFG_MISS_LIMIT, {junk[17:0], c.miss_limit});
        write_reg(CFG_HIT_LIMIT, {junk[31:14], c.hit_limit});
        write_reg(spare_idx, junk[25:0]);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        active = c;
    endtask

    // Shape a sample towards a hit, a miss or plain noise
    task automatic random_sample(input int lo, input int hi, input int hit_pct);
        int                     kind;
        int                     miss_pct;
        logic [JOINT_IDX_W-1:0] joint;
        logic [VALUE_W-1:0]     angle;
        logic [VALUE_W-1:0]     current;
        miss_pct = (100 - hit_pct) / 2;
        joint    = JOINT_IDX_W'(($urandom_range(99) < 85) ? $urandom_range(hi, lo)
                                                          : $urandom_range(31, 0));
        kind     = $urandom_range(99);
        angle    = VALUE_W'($urandom);
        current  = VALUE_W'($urandom);
        if (kind < hit_pct) begin
            if (active.angle_threshold != '1)
                angle = VALUE_W'($urandom_range(16'hFFFF, int'(active.angle_threshold) + 1));
            if (active.current_threshold != '0)
                current = VALUE_W'($urandom_range(int'(active.current_threshold) - 1, 0));
        end else if (kind < hit_pct + miss_pct) begin
            angle = VALUE_W'($urandom_range(int'(active.angle_threshold), 0));
        end
        send_sample(joint, angle, current, $urandom_range(99) < 5,
                    $urandom_range(99) >= 5, $urandom_range(7) == 0);
    endtask

    task automatic run_phase(input cfg_t c, input int lo, input int hi,
                             input int hit_pct, input int count);
        load_settings(c);
        repeat (count) random_sample(lo, hi, hit_pct);
        settle();
    endtask

    initial begin
        cfg_t c;

        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        s_valid         = 1'b0;
        s_joint_index   = '0;
        s_angle_error   = '0;
        s_motor_current = '0;
        s_body_dead     = 1'b0;
        s_sample_valid  = 1'b0;
        s_frame_last    = 1'b0;
        active          = '{DISABLED_MASK_RST, ANGLE_THRESHOLD_RST, CURRENT_THRESHOLD_RST,
                            MISS_LIMIT_RST, HIT_LIMIT_RST};
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset settings, threshold edges, extremes and skips
        send_sample(0, 16'hFFFF, 16'h0000, 0, 1, 0);
        send_sample(0, ANGLE_THRESHOLD_RST + 16'd1, CURRENT_THRESHOLD_RST - 16'd1, 0, 1, 0);
        send_sample(0, ANGLE_THRESHOLD_RST, 16'h0000, 0, 1, 0);
        send_sample(0, ANGLE_THRESHOLD_RST + 16'd1, CURRENT_THRESHOLD_RST, 0, 1, 0);
        send_sample(25, 16'h0000, 16'hFFFF, 0, 1, 0);
        send_sample(26, 16'hFFFF, 16'h0000, 0, 1, 0);
        send_sample(31, 16'hFFFF, 16'h0000, 0, 1, 0);
        send_sample(3, 16'hFFFF, 16'h0000, 1, 1, 0);
        send_sample(3, 16'hFFFF, 16'h0000, 0, 0, 1);
        send_sample(1, 16'h1000, 16'h0010, 0, 1, 1);
        settle();

        // Directed: zero limits, one disabled joint, flag across a frame end
        load_settings('{26'd1 << 2, ANGLE_THRESHOLD_RST, CURRENT_THRESHOLD_RST, 8'd0, 8'd0});
        send_sample(2, 16'hFFFF, 16'h0000, 0, 1, 0);
        send_sample(4, 16'hFFFF, 16'h0000, 0, 1, 0);
        send_sample(5, 16'h0000, 16'h0000, 0, 1, 0);
        send_sample(4, 16'h0000, 16'h0000, 0, 1, 1);
        send_sample(6, 16'h0000, 16'h0000, 0, 1, 0);
        send_sample(4, 16'hFFFF, 16'h0000, 0, 1, 1);
        settle();

        // Random: reset settings over all joints
        run_phase('{DISABLED_MASK_RST, ANGLE_THRESHOLD_RST, CURRENT_THRESHOLD_RST,
                    MISS_LIMIT_RST, HIT_LIMIT_RST}, 0, NUM_JOINTS - 1, 50, 200);

        // Random: drive one joint's hit counter into saturation, no idling
        steady = 1'b1;
        c = '{MASK_W'($urandom) & ~(26'd1 << 7), 16'h0000, 16'hFFFF,
              8'd254, 8'd254};
        run_phase(c, 7, 7, 95, 400);
        steady = 1'b0;

        // Random: every sample misses; the miss counter saturates and clears hits
        run_phase('{26'd0, 16'hFFFF, 16'h0000, 8'd254, 8'd0}, 7, 7, 50, 350);

        // Random: lowest settings, hits impossible
        run_phase('{26'd0, 16'h0000, 16'h0000, 8'd0, 8'd0}, 0, NUM_JOINTS - 1, 50, 150);

        // Random: random settings with small limits on a few joints
        c.disabled_mask     = MASK_W'($urandom);
        c.angle_threshold   = VALUE_W'($urandom_range(2000, 0));
        c.current_threshold = VALUE_W'($urandom);
        c.miss_limit        = LIMIT_W'($urandom_range(15, 0));
        c.hit_limit         = LIMIT_W'($urandom_range(15, 0));
        run_phase(c, 10, 13, 60, 250);

        // Random: every joint disabled
        run_phase('{{MASK_W{1'b1}}, 16'd100, 16'hF000, 8'd1, 8'd1}, 0, NUM_JOINTS - 1, 50, 60);

        // Random: short limits, busy frames
        run_phase('{26'd0, ANGLE_THRESHOLD_RST, CURRENT_THRESHOLD_RST, 8'd2, 8'd3},
                  0, 5, 60, 200);

        if (mismatches == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
